// ===== design/vatc_pkg.sv =====
// Package for the virtual APIC timer countdown: widths, register indexes, FSM states.
`default_nettype none
package vatc_pkg;

    localparam int TS_W    = 64;  // timestamp width
    localparam int CNT_W   = 32;  // count and divisor width
    localparam int DIVV_W  = 8;   // divide value width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_STEP_W = $clog2(TS_W);
    localparam int MUL_STEP_W = $clog2(DIVV_W);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_COUNTS_PER_UNIT = 3'd0;
    localparam cfg_idx_t REG_DIVIDE_VALUE    = 3'd1;
    localparam cfg_idx_t REG_INITIAL_COUNT   = 3'd2;
    localparam cfg_idx_t REG_MASKED          = 3'd3;
    localparam cfg_idx_t REG_EXITS_ENABLED   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN
    } state_t;

endpackage
`default_nettype wire

// ===== design/virtual_apic_timer_countdown_top.sv =====
// Top level of the virtual APIC timer countdown: bit-serial divide, serial multiply, count update.
`default_nettype none
//
//  Channel   Signals                                   Direction  Beat
//  -------   ---------------------------------------   ---------  ---------------------------
//  in        in_valid, in_ready, timestamp             input      one tick per beat
//  out       out_valid, out_ready, expired,            output     one result per input beat
//            interrupt_request, current_count
//  cfg       cfg_valid, cfg_ready, cfg_index,          input      one register write per beat
//            cfg_data
//
//  Steps: an unmasked tick runs the divider (restoring divider, one quotient bit per cycle),
//  the multiply (one divide_value bit per cycle, MSB first) and the update state; a masked
//  tick goes straight to the update state. The result becomes valid as the block turns
//  ready again, so the next tick can be taken while the result is shown.
//  The 64-step divider loop sets the rate; one tick is in flight at a time.
//  Reset clears the state (last timestamp, count) and the handshake, sets config defaults.
//  Output stalls: the result register holds the beat; a finished tick waits in the update
//  state until the result register is free. cfg is always ready.
//
module virtual_apic_timer_countdown_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // tick input
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [vatc_pkg::TS_W-1:0]     timestamp,
    // result output
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               expired,
    output logic                               interrupt_request,
    output logic [vatc_pkg::CNT_W-1:0]         current_count,
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire vatc_pkg::cfg_idx_t            cfg_index,
    input  wire logic [vatc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vatc_pkg::*;

    // config registers
    logic [CNT_W-1:0]  counts_per_unit_reg;
    logic [DIVV_W-1:0] divide_value_reg;
    logic [CNT_W-1:0]  initial_count_reg;
    logic              masked_reg;
    logic              exits_enabled_reg;

    // timer state
    logic [TS_W-1:0]   last_ts_reg,  last_ts_next;
    logic [CNT_W-1:0]  count_now_reg, count_now_next;

    // control
    state_t                 state_reg, state_next;
    logic [DIV_STEP_W-1:0]  dstep_reg, dstep_next;
    logic [MUL_STEP_W-1:0]  mstep_reg, mstep_next;
    logic                   tick_masked_reg, tick_masked_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [TS_W-1:0]   now_reg, now_next;      // timestamp of the tick in flight
    logic [TS_W-1:0]   quo_reg, quo_next;      // dividend in, quotient out
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [TS_W-1:0]   acc_reg, acc_next;      // scaled elapsed amount
    logic              expired_reg, expired_next;
    logic              irq_reg, irq_next;
    logic [CNT_W-1:0]  cur_count_reg, cur_count_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W+1:0]  diff;                   // top bit is the borrow
    logic              fire;
    logic              load;
    logic              in_take;

    assign cfg_ready         = 1'b1;
    assign in_ready          = (state_reg == S_IDLE);
    assign in_take           = in_valid && in_ready;
    assign out_valid         = out_valid_reg;
    assign expired           = expired_reg;
    assign interrupt_request = irq_reg;
    assign current_count     = cur_count_reg;

    // config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_per_unit_reg <= CNT_W'(1);
            divide_value_reg    <= DIVV_W'(1);
            initial_count_reg   <= '0;
            masked_reg          <= 1'b1;
            exits_enabled_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COUNTS_PER_UNIT: counts_per_unit_reg <= cfg_data[CNT_W-1:0];
                REG_DIVIDE_VALUE:    divide_value_reg    <= cfg_data[DIVV_W-1:0];
                REG_INITIAL_COUNT:   initial_count_reg   <= cfg_data[CNT_W-1:0];
                REG_MASKED:          masked_reg          <= cfg_data[0];
                REG_EXITS_ENABLED:   exits_enabled_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dstep_reg       <= '0;
            mstep_reg       <= '0;
            tick_masked_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_ts_reg     <= '0;
            count_now_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            dstep_reg       <= dstep_next;
            mstep_reg       <= mstep_next;
            tick_masked_reg <= tick_masked_next;
            out_valid_reg   <= out_valid_next;
            last_ts_reg     <= last_ts_next;
            count_now_reg   <= count_now_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        acc_reg       <= acc_next;
        expired_reg   <= expired_next;
        irq_reg       <= irq_next;
        cur_count_reg <= cur_count_next;
    end

    // one restoring divider step: shift in the next dividend bit, try the subtract;
    // a zero divisor never borrows, so the quotient comes out all ones
    assign trial = {rem_reg, quo_reg[TS_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, counts_per_unit_reg};

    // count only survives if the amount fits 32 bits and is below the count
    assign fire = !((acc_reg[TS_W-1:CNT_W] == '0) && (count_now_reg > acc_reg[CNT_W-1:0]));
    assign load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        dstep_next       = dstep_reg;
        mstep_next       = mstep_reg;
        tick_masked_next = tick_masked_reg;
        out_valid_next   = out_valid_reg;
        last_ts_next     = last_ts_reg;
        count_now_next   = count_now_reg;
        now_next         = now_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        acc_next         = acc_reg;
        expired_next     = expired_reg;
        irq_next         = irq_reg;
        cur_count_next   = cur_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    now_next         = timestamp;
                    quo_next         = timestamp - last_ts_reg;  // elapsed, wraps
                    rem_next         = '0;
                    dstep_next       = '0;
                    tick_masked_next = masked_reg;
                    state_next       = masked_reg ? S_FIN : S_DIV;
                end
            end

            S_DIV:
            begin
                if (!diff[CNT_W+1])
                begin
                    rem_next = diff[CNT_W-1:0];
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                end
                quo_next   = {quo_reg[TS_W-2:0], !diff[CNT_W+1]};
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == '1)
                begin
                    acc_next   = '0;
                    mstep_next = '1;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                // shift-and-add, MSB of divide_value first; wraps mod 2^64
                acc_next   = {acc_reg[TS_W-2:0], 1'b0}
                             + (divide_value_reg[mstep_reg] ? quo_reg : '0);
                mstep_next = mstep_reg - 1'b1;
                if (mstep_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (load)
                begin
                    if (tick_masked_reg)
                    begin
                        expired_next = 1'b0;
                        irq_next     = 1'b0;
                    end
                    else
                    begin
                        last_ts_next   = now_reg;
                        count_now_next = fire ? initial_count_reg
                                              : count_now_reg - acc_reg[CNT_W-1:0];
                        expired_next   = fire;
                        irq_next       = fire && !exits_enabled_reg;
                    end
                    cur_count_next = (tick_masked_reg || !fire)
                                     ? ((tick_masked_reg) ? count_now_reg
                                                          : count_now_reg - acc_reg[CNT_W-1:0])
                                     : initial_count_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // interrupt request only comes with an expiry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!interrupt_request || expired))
        else $error("interrupt_request without expired");

    // divider runs exactly 64 steps before the multiply
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (dstep_reg == '1) |=> (state_reg == S_MUL))
        else $error("divider did not hand over to multiply");

    // a result only appears out of the update state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside update");

    // without an expiry the count never goes up
    assert property (@(posedge clk) disable iff (!rst_n)
        load && (tick_masked_reg || !fire) |=> (count_now_reg <= $past(count_now_reg)))
        else $error("count rose without reload");

    // no new tick is taken while one is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !in_ready)
        else $error("tick accepted while busy");

endmodule
`default_nettype wire
